[hw/rtl/etc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etc_pkg
// Shared constants and controller/datapath interface types for the cache.
// ----------------------------------------------------------------------------
package etc_pkg;

    localparam int CAP_DEFAULT = 16;

    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;
    localparam int LEN_W    = 8;
    localparam int CHG_W    = 9;
    localparam int TIME_W   = 63;
    localparam int CAPR_W   = 5;
    localparam int MAXB_W   = 16;
    localparam int PURGE_W  = 5;
    localparam int CNT_W    = 5;
    localparam int BYTES_W  = 13;
    localparam int CODE_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_BUDGET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PURGE_QUOTA = 2'd2;

    localparam logic [CODE_W-1:0] CODE_IGNORED = 2'd0;
    localparam logic [CODE_W-1:0] CODE_OK      = 2'd1;
    localparam logic [CODE_W-1:0] CODE_LARGE   = 2'd2;
    localparam logic [CODE_W-1:0] CODE_EXPIRED = 2'd3;

    // Controller -> datapath commands.
    typedef struct packed {
        logic load;       // capture request, reset scan
        logic drop_tail;  // remove last entry
        logic scan_step;  // compare entry at scan pointer, advance on a miss
        logic shift_step; // move entry at ptr+1 down into ptr
        logic shift_done; // finish a removal: count and bytes down
        logic ptr_dec;    // step pointer back to the swap partner
        logic swap_a;     // swap: entry at ptr moves up to ptr+1
        logic swap_b;     // swap: held entry goes to ptr
        logic append;     // write request entry at tail
        logic set_code;
        logic [CODE_W-1:0] code;
        logic set_vout;
    } etc_cmd_t;

    // Datapath -> controller status.
    typedef struct packed {
        logic is_lookup;
        logic ins_bad;       // disabled or expired on arrival
        logic tail_expired;  // tail entry expired at now
        logic empty;
        logic purge_limit;   // purge count reached the purge quota
        logic too_large;
        logic over_cap;      // live count >= effective capacity
        logic over_bytes;    // total + need > budget
        logic scan_end;      // scan pointer reached live count
        logic scan_hit;      // entry at scan pointer matches key
        logic hit_expired;   // matched entry expired
        logic hit_at_head;
        logic shift_end;     // ptr+1 reached live count
    } etc_sts_t;

endpackage

[hw/rtl/etc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etc_datapath
// Entry store, counters, request registers and result register.
// ----------------------------------------------------------------------------
module etc_datapath #(
    parameter int CAP = etc_pkg::CAP_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [etc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [etc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_kind,
    input  logic [etc_pkg::KEY_W-1:0]     s_key,
    input  logic [etc_pkg::LEN_W-1:0]     s_key_bytes,
    input  logic [etc_pkg::VAL_W-1:0]     s_value,
    input  logic [etc_pkg::LEN_W-1:0]     s_value_bytes,
    input  logic [etc_pkg::TIME_W-1:0]    s_expiry,
    input  logic [etc_pkg::TIME_W-1:0]    s_now,
    input  etc_pkg::etc_cmd_t             cmd,
    output etc_pkg::etc_sts_t             sts,
    output logic [etc_pkg::CODE_W-1:0]    m_code,
    output logic [etc_pkg::VAL_W-1:0]     m_value_out,
    output logic [etc_pkg::CNT_W-1:0]     m_entries_used,
    output logic [etc_pkg::BYTES_W-1:0]   m_bytes_used
);
    localparam int PW = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int LW = $clog2(CAP + 1);
    localparam int BW = etc_pkg::BYTES_W + 8;

    typedef struct packed {
        logic [etc_pkg::KEY_W-1:0]  key;
        logic [etc_pkg::VAL_W-1:0]  val;
        logic [etc_pkg::CHG_W-1:0]  chg;
        logic [etc_pkg::TIME_W-1:0] exp;
    } ent_t;

    ent_t mem [CAP];

    logic [etc_pkg::CAPR_W-1:0]  capacity_reg;
    logic [etc_pkg::MAXB_W-1:0]  byte_budget_reg;
    logic [etc_pkg::PURGE_W-1:0] purge_quota_reg;

    logic                        kind_reg;
    ent_t                        req_reg;
    logic [etc_pkg::TIME_W-1:0]  now_reg;
    logic [LW-1:0]               live_reg;
    logic [BW-1:0]               total_reg;
    logic [LW-1:0]               ptr_reg;
    logic [etc_pkg::PURGE_W-1:0] purged_reg;
    ent_t                        hold_reg;
    ent_t                        tail_reg; // registered read at live-1
    ent_t                        rd_reg;   // registered read at ptr+1
    ent_t                        cur_reg;  // registered read at ptr

    logic [etc_pkg::CODE_W-1:0]  code_reg;
    logic [etc_pkg::VAL_W-1:0]   vout_reg;

    logic [LW-1:0] cap_eff;
    logic [LW-1:0] live_m1;
    logic [LW-1:0] ptr_p1;
    logic [BW-1:0] need_w;

    assign cap_eff = (int'(capacity_reg) > CAP) ? LW'(CAP) : LW'(capacity_reg);
    assign live_m1 = live_reg - LW'(1);
    assign ptr_p1  = ptr_reg + LW'(1);
    assign need_w  = BW'(req_reg.chg);

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg    <= etc_pkg::CAPR_W'(16);
            byte_budget_reg <= '0;
            purge_quota_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                etc_pkg::REG_CAPACITY:    capacity_reg    <= cfg_data[etc_pkg::CAPR_W-1:0];
                etc_pkg::REG_BYTE_BUDGET: byte_budget_reg <= cfg_data;
                etc_pkg::REG_PURGE_QUOTA: purge_quota_reg <= cfg_data[etc_pkg::PURGE_W-1:0];
                default: ;
            endcase
        end
    end

    // Memory: one write port, registered reads.
    always_ff @(posedge aclk) begin
        if (cmd.shift_step) begin
            mem[ptr_reg[PW-1:0]] <= rd_reg;
        end else if (cmd.swap_a) begin
            mem[ptr_p1[PW-1:0]] <= cur_reg; // entry from pos-1 goes to pos
        end else if (cmd.swap_b) begin
            mem[ptr_reg[PW-1:0]] <= hold_reg;
        end else if (cmd.append) begin
            mem[live_reg[PW-1:0]] <= req_reg;
        end
        tail_reg <= mem[live_m1[PW-1:0]];
        rd_reg   <= mem[ptr_p1[PW-1:0]];
    end

    // Request, counters, pointer
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg    <= s_kind;
            req_reg.key <= s_key;
            req_reg.val <= s_value;
            req_reg.chg <= etc_pkg::CHG_W'(s_key_bytes) + etc_pkg::CHG_W'(s_value_bytes);
            req_reg.exp <= s_expiry;
            now_reg     <= s_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg   <= '0;
            total_reg  <= '0;
            ptr_reg    <= '0;
            purged_reg <= '0;
            code_reg   <= '0;
            vout_reg   <= '0;
        end else begin
            if (cmd.load) begin
                ptr_reg    <= '0;
                purged_reg <= '0;
                vout_reg   <= '0;
            end
            if (cmd.drop_tail) begin
                live_reg   <= live_m1;
                total_reg  <= total_reg - BW'(tail_reg.chg);
                purged_reg <= purged_reg + etc_pkg::PURGE_W'(1);
            end
            if (cmd.scan_step && !sts.scan_hit) begin
                ptr_reg <= ptr_p1;
            end
            if (cmd.scan_step && sts.scan_hit) begin
                hold_reg <= cur_reg;
            end
            if (cmd.shift_step) begin
                ptr_reg <= ptr_p1;
            end
            if (cmd.shift_done) begin
                live_reg  <= live_m1;
                total_reg <= total_reg - BW'(hold_reg.chg);
            end
            if (cmd.ptr_dec) begin
                ptr_reg <= ptr_reg - LW'(1);
            end
            if (cmd.append) begin
                live_reg  <= live_reg + LW'(1);
                total_reg <= total_reg + need_w;
            end
            if (cmd.set_code) begin
                code_reg <= cmd.code;
            end
            if (cmd.set_vout) begin
                vout_reg <= hold_reg.val;
            end
        end
    end

    // Scan compares the entry at ptr, read in the cycle before.
    always_ff @(posedge aclk) begin
        cur_reg <= mem[ptr_reg[PW-1:0]];
    end

    always_comb begin
        sts = '0;
        sts.is_lookup    = kind_reg;
        sts.ins_bad      = (capacity_reg == '0) || (req_reg.exp <= now_reg);
        sts.empty        = (live_reg == '0);
        sts.tail_expired = (now_reg >= tail_reg.exp);
        sts.purge_limit  = (purge_quota_reg != '0) && (purged_reg >= purge_quota_reg);
        sts.too_large    = (byte_budget_reg != '0) && (need_w > BW'(byte_budget_reg));
        sts.over_cap     = (live_reg >= cap_eff);
        sts.over_bytes   = (byte_budget_reg != '0) &&
                           ((total_reg + need_w) > BW'(byte_budget_reg));
        sts.scan_end     = (ptr_reg >= live_reg);
        sts.scan_hit     = (cur_reg.key == req_reg.key);
        sts.hit_expired  = (now_reg >= hold_reg.exp);
        sts.hit_at_head  = (ptr_reg == '0);
        sts.shift_end    = (ptr_p1 >= live_reg);
    end

    assign m_code         = code_reg;
    assign m_value_out    = vout_reg;
    assign m_entries_used = etc_pkg::CNT_W'(live_reg);
    assign m_bytes_used   = total_reg[etc_pkg::BYTES_W-1:0];
endmodule

[hw/rtl/etc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etc_ctrl
// Sequencer for purge, search, removal, eviction, append and swap.
// ----------------------------------------------------------------------------
module etc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  etc_pkg::etc_sts_t sts,
    output etc_pkg::etc_cmd_t cmd
);
    // Every memory read is registered, so states that inspect an entry are
    // preceded by a settle state (_W) in which the read is registered.
    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_START   = 17'h00002,
        S_PURGE_W = 17'h00004,
        S_PURGE   = 17'h00008,
        S_SCAN_W  = 17'h00010,
        S_SCAN    = 17'h00020,
        S_HIT     = 17'h00040,
        S_SHIFT_W = 17'h00080,
        S_SHIFT   = 17'h00100,
        S_EVC_W   = 17'h00200,
        S_EVICT   = 17'h00400,
        S_APPEND  = 17'h00800,
        S_SWAP_W  = 17'h01000,
        S_SWAP_A  = 17'h02000,
        S_SWAP_B  = 17'h04000,
        S_OUT     = 17'h08000,
        S_DONE    = 17'h10000
    } state_t;

    state_t state_reg, state_next;
    logic   large_reg, large_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    always_comb begin
        state_next = state_reg;
        large_next = large_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                large_next = 1'b0;
                if (sts.is_lookup) begin
                    state_next = S_SCAN_W;
                end else if (sts.ins_bad) begin
                    cmd.set_code = 1'b1;
                    cmd.code     = etc_pkg::CODE_IGNORED;
                    state_next   = S_OUT;
                end else begin
                    state_next = S_PURGE_W;
                end
            end
            S_PURGE_W: state_next = S_PURGE;
            S_PURGE: begin
                if (!sts.empty && sts.tail_expired && !sts.purge_limit) begin
                    cmd.drop_tail = 1'b1;
                    state_next    = S_PURGE_W;
                end else begin
                    large_next = sts.too_large;
                    state_next = S_SCAN_W;
                end
            end
            S_SCAN_W: state_next = S_SCAN;
            S_SCAN: begin
                cmd.scan_step = !sts.scan_end;
                if (sts.scan_end) begin
                    if (sts.is_lookup) begin
                        cmd.set_code = 1'b1;
                        cmd.code     = etc_pkg::CODE_IGNORED;
                        state_next   = S_OUT;
                    end else if (large_reg) begin
                        cmd.set_code = 1'b1;
                        cmd.code     = etc_pkg::CODE_LARGE;
                        state_next   = S_OUT;
                    end else begin
                        state_next = S_EVC_W;
                    end
                end else if (sts.scan_hit) begin
                    state_next = S_HIT;
                end else begin
                    state_next = S_SCAN_W;
                end
            end
            S_HIT: begin
                if (sts.is_lookup && !sts.hit_expired) begin
                    cmd.set_vout = 1'b1;
                    cmd.set_code = 1'b1;
                    cmd.code     = etc_pkg::CODE_OK;
                    cmd.ptr_dec  = !sts.hit_at_head;
                    state_next   = sts.hit_at_head ? S_OUT : S_SWAP_W;
                end else begin
                    state_next = S_SHIFT_W;
                end
            end
            S_SHIFT_W: state_next = S_SHIFT;
            S_SHIFT: begin
                if (sts.shift_end) begin
                    cmd.shift_done = 1'b1;
                    if (sts.is_lookup) begin
                        cmd.set_code = 1'b1;
                        cmd.code     = etc_pkg::CODE_EXPIRED;
                        state_next   = S_OUT;
                    end else if (large_reg) begin
                        cmd.set_code = 1'b1;
                        cmd.code     = etc_pkg::CODE_LARGE;
                        state_next   = S_OUT;
                    end else begin
                        state_next = S_EVC_W;
                    end
                end else begin
                    cmd.shift_step = 1'b1;
                    state_next     = S_SHIFT_W;
                end
            end
            S_EVC_W: state_next = S_EVICT;
            S_EVICT: begin
                if (!sts.empty && (sts.over_cap || sts.over_bytes)) begin
                    cmd.drop_tail = 1'b1;
                    state_next    = S_EVC_W;
                end else begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND: begin
                cmd.append   = 1'b1;
                cmd.set_code = 1'b1;
                cmd.code     = etc_pkg::CODE_OK;
                state_next   = S_OUT;
            end
            S_SWAP_W: state_next = S_SWAP_A;
            S_SWAP_A: begin
                cmd.swap_a = 1'b1;
                state_next = S_SWAP_B;
            end
            S_SWAP_B: begin
                cmd.swap_b = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_DONE;
                end
            end
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            large_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            large_reg <= large_next;
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("ready while result pending");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped");
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.shift_step, cmd.swap_a, cmd.swap_b, cmd.append}))
        else $error("memory write conflict");
`endif
endmodule

[hw/rtl/expiring_transpose_cache.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expiring_transpose_cache
// TTL cache kept as an ordered list with transpose-on-hit promotion.
// ----------------------------------------------------------------------------
// Channel   | Ports                                  | Handshake
// ----------+----------------------------------------+----------------
// request   | s_kind s_key s_key_bytes s_value ...   | s_valid/s_ready
// result    | m_code m_value_out m_entries_used ...  | m_valid/m_ready
// config    | cfg_we cfg_index cfg_data              | write enable
//
// One request at a time. Each step over an entry is a registered memory read,
// then an act. An insert purges, scans, shifts out an old copy, evicts and
// appends, one entry per step; a promoting lookup hit adds a swap.
// Reset (aresetn, synchronous) clears counts; entry storage is left as is.
// The result register holds until m_ready; the next request is taken after.
// ----------------------------------------------------------------------------
module expiring_transpose_cache #(
    parameter int CAP = etc_pkg::CAP_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [etc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [etc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [etc_pkg::KEY_W-1:0]     s_key,
    input  logic [etc_pkg::LEN_W-1:0]     s_key_bytes,
    input  logic [etc_pkg::VAL_W-1:0]     s_value,
    input  logic [etc_pkg::LEN_W-1:0]     s_value_bytes,
    input  logic [etc_pkg::TIME_W-1:0]    s_expiry,
    input  logic [etc_pkg::TIME_W-1:0]    s_now,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [etc_pkg::CODE_W-1:0]    m_code,
    output logic [etc_pkg::VAL_W-1:0]     m_value_out,
    output logic [etc_pkg::CNT_W-1:0]     m_entries_used,
    output logic [etc_pkg::BYTES_W-1:0]   m_bytes_used
);
    etc_pkg::etc_cmd_t cmd;
    etc_pkg::etc_sts_t sts;

    // Sequencer
    etc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Entry store and arithmetic
    etc_datapath #(.CAP(CAP)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_kind         (s_kind),
        .s_key          (s_key),
        .s_key_bytes    (s_key_bytes),
        .s_value        (s_value),
        .s_value_bytes  (s_value_bytes),
        .s_expiry       (s_expiry),
        .s_now          (s_now),
        .cmd            (cmd),
        .sts            (sts),
        .m_code         (m_code),
        .m_value_out    (m_value_out),
        .m_entries_used (m_entries_used),
        .m_bytes_used   (m_bytes_used)
    );
endmodule

[tb/sv/tb_expiring_transpose_cache.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_expiring_transpose_cache
// Drives insert and lookup requests into the TTL cache and checks every result
// against a cycle-free list model of the cache, under random idling on both
// channels and several budget, capacity and purge-limit settings.
// ----------------------------------------------------------------------------
module tb_expiring_transpose_cache;

    localparam int NCAP = etc_pkg::CAP_DEFAULT;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic [etc_pkg::CODE_W-1:0]  code;
        logic [etc_pkg::VAL_W-1:0]   value_out;
        logic [etc_pkg::CNT_W-1:0]   entries;
        logic [etc_pkg::BYTES_W-1:0] bytes;
    } cache_result_t;

    typedef struct {
        logic                        kind;
        logic [etc_pkg::KEY_W-1:0]   key;
        logic [etc_pkg::LEN_W-1:0]   key_bytes;
        logic [etc_pkg::VAL_W-1:0]   value;
        logic [etc_pkg::LEN_W-1:0]   value_bytes;
        logic [etc_pkg::TIME_W-1:0]  expiry;
        logic [etc_pkg::TIME_W-1:0]  now;
    } cache_req_t;

    // Shadow list of the cache: position 0 is the hot end.
    class cache_scoreboard;
        logic [etc_pkg::KEY_W-1:0]   ekey[NCAP];
        logic [etc_pkg::VAL_W-1:0]   eval[NCAP];
        logic [etc_pkg::CHG_W-1:0]   echg[NCAP];
        logic [etc_pkg::TIME_W-1:0]  eexp[NCAP];
        int                          live;
        int                          total;
        int                          capacity;
        int                          byte_budget;
        int                          purge_quota;
        cache_result_t               pending[$];
        int                          errors;

        function new();
            live = 0; total = 0;
            capacity = 16; byte_budget = 0; purge_quota = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [etc_pkg::CFG_IDX_W-1:0] idx,
                              logic [etc_pkg::CFG_W-1:0] d);
            case (idx)
                etc_pkg::REG_CAPACITY:    capacity    = d[etc_pkg::CAPR_W-1:0];
                etc_pkg::REG_BYTE_BUDGET: byte_budget = d;
                etc_pkg::REG_PURGE_QUOTA: purge_quota = d[etc_pkg::PURGE_W-1:0];
                default: ;
            endcase
        endfunction

        function void remove_at(int pos);
            total -= echg[pos];
            for (int i = pos; i + 1 < live; i++) begin
                ekey[i] = ekey[i+1]; eval[i] = eval[i+1];
                echg[i] = echg[i+1]; eexp[i] = eexp[i+1];
            end
            live--;
        endfunction

        function int find(logic [etc_pkg::KEY_W-1:0] k);
            for (int i = 0; i < live; i++)
                if (ekey[i] == k) return i;
            return -1;
        endfunction

        function logic [etc_pkg::CODE_W-1:0] insert(cache_req_t r);
            int need;
            int cap_eff;
            int pos;
            int done;
            need = r.key_bytes + r.value_bytes;
            cap_eff = capacity > NCAP ? NCAP : capacity;
            if (capacity == 0 || r.expiry <= r.now) return etc_pkg::CODE_IGNORED;
            done = 0;
            while (live > 0 && r.now >= eexp[live-1]) begin
                remove_at(live - 1);
                done++;
                if (purge_quota != 0 && done >= purge_quota) break;
            end
            pos = find(r.key);
            if (byte_budget != 0 && need > byte_budget) begin
                if (pos >= 0) remove_at(pos);
                return etc_pkg::CODE_LARGE;
            end
            if (pos >= 0) remove_at(pos);
            while (live > 0 && live >= cap_eff) remove_at(live - 1);
            while (live > 0 && byte_budget != 0 && total + need > byte_budget)
                remove_at(live - 1);
            ekey[live] = r.key; eval[live] = r.value;
            echg[live] = etc_pkg::CHG_W'(need); eexp[live] = r.expiry;
            live++;
            total += need;
            return etc_pkg::CODE_OK;
        endfunction

        // Note an accepted request and queue its expected result.
        function void note_request(cache_req_t r);
            cache_result_t e;
            int pos;
            e.value_out = '0;
            if (r.kind == 1'b0) begin
                e.code = insert(r);
            end else begin
                pos = find(r.key);
                if (pos < 0) begin
                    e.code = etc_pkg::CODE_IGNORED;
                end else if (r.now >= eexp[pos]) begin
                    remove_at(pos);
                    e.code = etc_pkg::CODE_EXPIRED;
                end else begin
                    e.code = etc_pkg::CODE_OK;
                    e.value_out = eval[pos];
                    if (pos > 0) begin
                        ekey[pos] = ekey[pos-1]; ekey[pos-1] = r.key;
                        eval[pos] = eval[pos-1]; eval[pos-1] = e.value_out;
                        {echg[pos], echg[pos-1]} = {echg[pos-1], echg[pos]};
                        {eexp[pos], eexp[pos-1]} = {eexp[pos-1], eexp[pos]};
                    end
                end
            end
            e.entries = etc_pkg::CNT_W'(live);
            e.bytes = etc_pkg::BYTES_W'(total);
            pending.push_back(e);
        endfunction

        function void check_result(cache_result_t a);
            cache_result_t e;
            if (pending.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.code !== e.code) begin
                $error("code: expected %0d, got %0d", e.code, a.code); errors++;
            end
            if (a.value_out !== e.value_out) begin
                $error("value_out: expected %h, got %h", e.value_out, a.value_out);
                errors++;
            end
            if (a.entries !== e.entries) begin
                $error("entries_used: expected %0d, got %0d", e.entries, a.entries);
                errors++;
            end
            if (a.bytes !== e.bytes) begin
                $error("bytes_used: expected %0d, got %0d", e.bytes, a.bytes);
                errors++;
            end
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [etc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [etc_pkg::CFG_W-1:0]     cfg_data = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_kind = 1'b0;
    logic [etc_pkg::KEY_W-1:0]     s_key = '0;
    logic [etc_pkg::LEN_W-1:0]     s_key_bytes = '0;
    logic [etc_pkg::VAL_W-1:0]     s_value = '0;
    logic [etc_pkg::LEN_W-1:0]     s_value_bytes = '0;
    logic [etc_pkg::TIME_W-1:0]    s_expiry = '0;
    logic [etc_pkg::TIME_W-1:0]    s_now = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [etc_pkg::CODE_W-1:0]    m_code;
    logic [etc_pkg::VAL_W-1:0]     m_value_out;
    logic [etc_pkg::CNT_W-1:0]     m_entries_used;
    logic [etc_pkg::BYTES_W-1:0]   m_bytes_used;

    expiring_transpose_cache u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_key(s_key),
        .s_key_bytes(s_key_bytes), .s_value(s_value), .s_value_bytes(s_value_bytes),
        .s_expiry(s_expiry), .s_now(s_now),
        .m_valid(m_valid), .m_ready(m_ready), .m_code(m_code),
        .m_value_out(m_value_out), .m_entries_used(m_entries_used),
        .m_bytes_used(m_bytes_used)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    cache_scoreboard sb = new();
    int send_idle_pct = 38;
    int recv_idle_pct = 78;
    int stall_cycles = 0;
    bit timed_out = 1'b0;
    logic [etc_pkg::TIME_W-1:0] clock_ns = 63'd1000;   // running notion of "now"
    logic [etc_pkg::KEY_W-1:0]  key_pool[8];

    // Receiver: random back-pressure, check on every accepted result.
    always @(posedge aclk) begin
        cache_result_t r;
        if (aresetn && m_valid && m_ready) begin
            r.code = m_code; r.value_out = m_value_out;
            r.entries = m_entries_used; r.bytes = m_bytes_used;
            sb.check_result(r);
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: cycles with no handshake on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("expiring_transpose_cache test failed");
            $finish;
        end
    end

    task automatic write_reg(logic [etc_pkg::CFG_IDX_W-1:0] idx,
                             logic [etc_pkg::CFG_W-1:0] d);
        @(posedge aclk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= d;
        sb.set_reg(idx, d);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Hold the request until accepted; idle gaps are inserted before it.
    task automatic send(cache_req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1; s_kind <= r.kind; s_key <= r.key;
        s_key_bytes <= r.key_bytes; s_value <= r.value;
        s_value_bytes <= r.value_bytes; s_expiry <= r.expiry; s_now <= r.now;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(r);
    endtask

    // Wait until every result is back, then let the block go fully idle.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    // Mostly well-formed traffic over a small key pool so hits, replacements,
    // expiries and evictions happen often; occasional random keys and times.
    function automatic cache_req_t rand_req();
        cache_req_t r;
        r.kind = $urandom_range(99) < 55;
        r.key = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                         : key_pool[$urandom_range(7)];
        r.key_bytes = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(40));
        r.value_bytes = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(40));
        r.value = {$urandom, $urandom};
        clock_ns = clock_ns + $urandom_range(30);
        r.now = clock_ns;
        case ($urandom_range(9))
            0: r.expiry = r.now - $urandom_range(5);         // already expired
            1: r.expiry = etc_pkg::TIME_W'({$urandom, $urandom}); // anything at all
            default: r.expiry = r.now + 1 + $urandom_range(300);
        endcase
        if ($urandom_range(49) == 0) r.now = etc_pkg::TIME_W'({$urandom, $urandom});
        return r;
    endfunction

    function automatic cache_req_t mk(logic kind, logic [etc_pkg::KEY_W-1:0] key,
                                      int kb, int vb, logic [etc_pkg::TIME_W-1:0] exp,
                                      logic [etc_pkg::TIME_W-1:0] now);
        cache_req_t r;
        r.kind = kind; r.key = key;
        r.key_bytes = etc_pkg::LEN_W'(kb); r.value_bytes = etc_pkg::LEN_W'(vb);
        r.value = {$urandom, $urandom}; r.expiry = exp; r.now = now;
        return r;
    endfunction

    initial begin
        logic [etc_pkg::TIME_W-1:0] tmax;
        tmax = '1;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, hits, head hit, expiry on lookup, too large.
        send(mk(1'b0, key_pool[0], 0, 0, 100, 10));
        send(mk(1'b0, key_pool[1], 255, 255, tmax, 10));
        send(mk(1'b1, key_pool[1], 0, 0, 0, 20));         // hit, moves to head
        send(mk(1'b1, key_pool[1], 0, 0, 0, 21));         // head hit
        send(mk(1'b1, key_pool[2], 0, 0, 0, 22));         // miss
        send(mk(1'b0, key_pool[2], 3, 4, 30, 30));        // expired on arrival
        send(mk(1'b1, key_pool[0], 0, 0, 0, 100));        // expired and removed
        send(mk(1'b0, key_pool[3], 1, 1, 200, 50));
        send(mk(1'b0, key_pool[3], 2, 2, 300, 60));       // replace old copy
        send(mk(1'b1, key_pool[3], 9, 9, tmax, tmax - 1));
        drain();

        write_reg(etc_pkg::REG_BYTE_BUDGET, 16'd20);
        write_reg(etc_pkg::REG_PURGE_QUOTA, 16'd1);
        write_reg(etc_pkg::REG_CAPACITY, 16'd3);
        send(mk(1'b0, key_pool[4], 5, 5, 500, 100));
        send(mk(1'b0, key_pool[5], 5, 5, 110, 100));
        send(mk(1'b0, key_pool[6], 5, 4, 110, 100));      // byte eviction
        send(mk(1'b0, key_pool[4], 15, 15, 900, 105));    // too large, drops copy
        send(mk(1'b0, key_pool[7], 1, 1, 900, 200));      // purge limited to one
        send(mk(1'b0, key_pool[2], 1, 1, 900, 200));
        send(mk(1'b0, key_pool[3], 1, 1, 900, 200));      // fills to capacity
        drain();
        write_reg(etc_pkg::REG_CAPACITY, 16'd0);
        send(mk(1'b0, key_pool[1], 1, 1, 900, 200));      // disabled
        drain();
        write_reg(etc_pkg::REG_CAPACITY, 16'd31);         // clamped to CAP
        write_reg(etc_pkg::REG_BYTE_BUDGET, 16'hFFFF);
        write_reg(etc_pkg::REG_PURGE_QUOTA, 16'd31);
        clock_ns = 63'd1000;

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin send_idle_pct = 78; recv_idle_pct = 38; end
            if (phase == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            for (int n = 0; n < 95; n++) send(rand_req());
            drain();
            write_reg(etc_pkg::REG_CAPACITY, 16'($urandom_range(16)));
            write_reg(etc_pkg::REG_BYTE_BUDGET,
                      ($urandom_range(1)) ? 16'($urandom_range(300)) : 16'd0);
            write_reg(etc_pkg::REG_PURGE_QUOTA, 16'($urandom_range(16)));
            for (int n = 0; n < 95; n++) send(rand_req());
            drain();
            write_reg(etc_pkg::REG_CAPACITY, 16'd16);
            write_reg(etc_pkg::REG_BYTE_BUDGET, 16'd0);
            write_reg(etc_pkg::REG_PURGE_QUOTA, 16'd0);
            for (int n = 0; n < 90; n++) send(rand_req());
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("expiring_transpose_cache test passed");
        else
            $display("expiring_transpose_cache test failed");
        $finish;
    end
endmodule

[filelist.f]
hw/rtl/etc_pkg.sv
hw/rtl/etc_datapath.sv
hw/rtl/etc_ctrl.sv
hw/rtl/expiring_transpose_cache.sv
tb/sv/tb_expiring_transpose_cache.sv
